// ===== rtl/cts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants for the cut truth-table simulator
// Sizes, command and result records, elementary table patterns.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int SLOTS       = 256;
  localparam int TRUTH_WORDS = 4;
  localparam int MAX_VARS    = 8;

  localparam int SLOT_W     = 8;
  localparam int WORD_W     = 64;
  localparam int WIDX_OUT_W = 2;
  localparam int WIDX_W     = (TRUTH_WORDS > 1) ? $clog2(TRUTH_WORDS) : 1;

  localparam int STORE_DEPTH = SLOTS * TRUTH_WORDS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int CQ_CNT_W = 2;

  // result queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = 3;
  localparam int OQ_CNT_W = 4;

  localparam logic REQ_LEAF = 1'b0;
  localparam logic REQ_NODE = 1'b1;

  localparam logic [WORD_W-1:0] PAT_V0 = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [WORD_W-1:0] PAT_V1 = 64'hCCCC_CCCC_CCCC_CCCC;
  localparam logic [WORD_W-1:0] PAT_V2 = 64'hF0F0_F0F0_F0F0_F0F0;
  localparam logic [WORD_W-1:0] PAT_V3 = 64'hFF00_FF00_FF00_FF00;
  localparam logic [WORD_W-1:0] PAT_V4 = 64'hFFFF_0000_FFFF_0000;
  localparam logic [WORD_W-1:0] PAT_V5 = 64'hFFFF_FFFF_0000_0000;
  localparam logic [WORD_W-1:0] PAT_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] PAT_ZEROS = 64'h0000_0000_0000_0000;

  typedef struct packed {
    logic              is_node;
    logic [SLOT_W-1:0] dest;
    logic [SLOT_W-1:0] fanin0;
    logic [SLOT_W-1:0] fanin1;
    logic              compl0;
    logic              compl1;
    logic              is_xor;
    logic              emit;
    logic              dest_ok;
    logic              fanin0_ok;
    logic              fanin1_ok;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]     truth_word;
    logic [WIDX_OUT_W-1:0] word_index;
    logic                  last;
  } res_t;

  // word w of the elementary table of variable var_num
  function automatic logic [WORD_W-1:0] elem_word(input logic [SLOT_W-1:0] var_num,
                                                  input logic [1:0] w);
    logic [WORD_W-1:0] pat;
    case (var_num)
      8'd0:    pat = PAT_V0;
      8'd1:    pat = PAT_V1;
      8'd2:    pat = PAT_V2;
      8'd3:    pat = PAT_V3;
      8'd4:    pat = PAT_V4;
      8'd5:    pat = PAT_V5;
      8'd6:    pat = w[0] ? PAT_ONES : PAT_ZEROS;
      8'd7:    pat = w[1] ? PAT_ONES : PAT_ZEROS;
      default: pat = PAT_ZEROS;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cts_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_front: item intake and classification
// Drops leaves beyond the cut, checks slot ranges, queues commands.
// ----------------------------------------------------------------------------
module cts_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic                       in_req_type,
  input  wire logic [cts_pkg::SLOT_W-1:0] in_dest_slot,
  input  wire logic [cts_pkg::SLOT_W-1:0] in_fanin0_slot,
  input  wire logic [cts_pkg::SLOT_W-1:0] in_fanin1_slot,
  input  wire logic                       in_fanin0_compl,
  input  wire logic                       in_fanin1_compl,
  input  wire logic                       in_is_xor,
  input  wire logic                       in_emit,
  output logic                            cmd_valid,
  output cts_pkg::cmd_t                   cmd,
  input  wire logic                       cmd_pop
);

  cts_pkg::cmd_t                    q_r [cts_pkg::CQ_DEPTH];
  logic [cts_pkg::CQ_PTR_W-1:0]     head_r, head_nxt;
  logic [cts_pkg::CQ_PTR_W-1:0]     tail_r, tail_nxt;
  logic [cts_pkg::CQ_CNT_W-1:0]     cnt_r, cnt_nxt;
  cts_pkg::cmd_t                    new_cmd;
  logic                             accept;
  logic                             keep;
  logic                             push;
  logic                             pop;

  always_comb begin
    new_cmd.is_node   = (in_req_type == cts_pkg::REQ_NODE);
    new_cmd.dest      = in_dest_slot;
    new_cmd.fanin0    = in_fanin0_slot;
    new_cmd.fanin1    = in_fanin1_slot;
    new_cmd.compl0    = in_fanin0_compl;
    new_cmd.compl1    = in_fanin1_compl;
    new_cmd.is_xor    = in_is_xor;
    new_cmd.emit      = in_emit;
    new_cmd.dest_ok   = int'(in_dest_slot) < cts_pkg::SLOTS;
    new_cmd.fanin0_ok = int'(in_fanin0_slot) < cts_pkg::SLOTS;
    new_cmd.fanin1_ok = int'(in_fanin1_slot) < cts_pkg::SLOTS;
  end

  assign in_full   = (cnt_r == cts_pkg::CQ_CNT_W'(cts_pkg::CQ_DEPTH));
  assign accept    = in_push && !in_full;
  // leaves beyond the cut write nothing and send nothing
  assign keep      = new_cmd.is_node || (int'(in_dest_slot) < cts_pkg::MAX_VARS);
  assign push      = accept && keep;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[head_r];

  always_comb begin
    head_nxt = pop  ? head_r + 1'b1 : head_r;
    tail_nxt = push ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cts_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_back: table store and word sequencer
// Once an item starts, one word per cycle: read fanins, combine, write back, emit.
// ----------------------------------------------------------------------------
module cts_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cmd_valid,
  input  wire cts_pkg::cmd_t                cmd,
  output logic                              cmd_pop,
  input  wire logic [cts_pkg::OQ_CNT_W-1:0] oq_count,
  output logic                              res_push,
  output cts_pkg::res_t                     res
);

  localparam logic [cts_pkg::WIDX_W-1:0] LAST_WORD = cts_pkg::WIDX_W'(cts_pkg::TRUTH_WORDS - 1);

  function automatic logic [cts_pkg::ADDR_W-1:0] word_addr(
      input logic [cts_pkg::SLOT_W-1:0] slot, input logic [cts_pkg::WIDX_W-1:0] w);
    return cts_pkg::ADDR_W'(int'(slot) * cts_pkg::TRUTH_WORDS + int'(w));
  endfunction

  logic [cts_pkg::WORD_W-1:0] mem [cts_pkg::STORE_DEPTH];

  // issue stage
  logic                         busy_r, busy_nxt;
  logic [cts_pkg::WIDX_W-1:0]   word_r, word_nxt;
  cts_pkg::cmd_t                cur_r, cur_nxt;
  logic [cts_pkg::OQ_CNT_W-1:0] pend_r, pend_nxt;
  logic                         credit_ok;
  logic                         start;
  logic                         issue_valid;
  cts_pkg::cmd_t                issue_cmd;
  logic [cts_pkg::WIDX_W-1:0]   issue_word;
  logic [cts_pkg::ADDR_W-1:0]   rd0_addr, rd1_addr;

  // combine stage
  logic                         s_valid_r;
  cts_pkg::cmd_t                s_cmd_r;
  logic [cts_pkg::WIDX_W-1:0]   s_word_r;
  logic [cts_pkg::WORD_W-1:0]   rd0_q, rd1_q;
  logic                         byp0_r, byp1_r;
  logic [cts_pkg::WORD_W-1:0]   wdat_r;
  logic [cts_pkg::WORD_W-1:0]   opa, opb, result;
  logic                         wr_en;
  logic [cts_pkg::ADDR_W-1:0]   wr_addr;

  // an emitting item starts only with room for all its words in the result queue
  assign credit_ok = !cmd.emit ||
      ((cts_pkg::OQ_DEPTH - int'(oq_count) - int'(pend_r)) >= cts_pkg::TRUTH_WORDS);
  assign start       = !busy_r && cmd_valid && credit_ok;
  assign cmd_pop     = start;
  assign issue_valid = busy_r || start;
  assign issue_cmd   = busy_r ? cur_r : cmd;
  assign issue_word  = busy_r ? word_r : '0;
  assign rd0_addr    = issue_cmd.fanin0_ok ? word_addr(issue_cmd.fanin0, issue_word) : '0;
  assign rd1_addr    = issue_cmd.fanin1_ok ? word_addr(issue_cmd.fanin1, issue_word) : '0;

  always_comb begin
    busy_nxt = busy_r;
    word_nxt = word_r;
    cur_nxt  = cur_r;
    if (issue_valid) begin
      cur_nxt = issue_cmd;
      if (issue_word == LAST_WORD) begin
        busy_nxt = 1'b0;
        word_nxt = '0;
      end else begin
        busy_nxt = 1'b1;
        word_nxt = issue_word + 1'b1;
      end
    end
    pend_nxt = pend_r;
    if (start && cmd.emit) begin
      pend_nxt = pend_nxt + cts_pkg::OQ_CNT_W'(cts_pkg::TRUTH_WORDS);
    end
    if (res_push) begin
      pend_nxt = pend_nxt - 1'b1;
    end
  end

  always_comb begin
    opa = byp0_r ? wdat_r : rd0_q;
    opb = byp1_r ? wdat_r : rd1_q;
    if (!s_cmd_r.fanin0_ok) opa = '0;
    if (!s_cmd_r.fanin1_ok) opb = '0;
    if (!s_cmd_r.is_node) begin
      result = cts_pkg::elem_word(s_cmd_r.dest, 2'(s_word_r));
    end else if (s_cmd_r.is_xor) begin
      result = opa ^ opb;
    end else begin
      result = (s_cmd_r.compl0 ? ~opa : opa) & (s_cmd_r.compl1 ? ~opb : opb);
    end
  end

  assign wr_en          = s_valid_r && s_cmd_r.dest_ok;
  assign wr_addr        = word_addr(s_cmd_r.dest, s_word_r);
  assign res_push       = s_valid_r && s_cmd_r.emit;
  assign res.truth_word = result;
  assign res.word_index = cts_pkg::WIDX_OUT_W'(s_word_r);
  assign res.last       = (s_word_r == LAST_WORD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      word_r    <= '0;
      pend_r    <= '0;
      s_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      word_r    <= word_nxt;
      pend_r    <= pend_nxt;
      s_valid_r <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    s_cmd_r  <= issue_cmd;
    s_word_r <= issue_word;
  end

  // table store; a read of the word being written takes the new data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= result;
    end
    if (issue_valid) begin
      rd0_q <= mem[rd0_addr];
      rd1_q <= mem[rd1_addr];
    end
    byp0_r <= wr_en && (wr_addr == rd0_addr);
    byp1_r <= wr_en && (wr_addr == rd1_addr);
    wdat_r <= result;
  end

endmodule
`default_nettype wire

// ===== rtl/cts_out_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cts_out_queue: result queue
// Holds table words until the consumer pops them.
// ----------------------------------------------------------------------------
module cts_out_queue (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         res_push,
  input  wire cts_pkg::res_t                res,
  output logic [cts_pkg::OQ_CNT_W-1:0]      oq_count,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output cts_pkg::res_t                     out_res
);

  cts_pkg::res_t                q_r [cts_pkg::OQ_DEPTH];
  logic [cts_pkg::OQ_PTR_W-1:0] head_r, head_nxt;
  logic [cts_pkg::OQ_PTR_W-1:0] tail_r, tail_nxt;
  logic [cts_pkg::OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         pop;

  assign out_empty = (cnt_r == '0);
  assign pop       = out_pop && !out_empty;
  assign out_res   = q_r[head_r];
  assign oq_count  = cnt_r;

  always_comb begin
    head_nxt = pop      ? head_r + 1'b1 : head_r;
    tail_nxt = res_push ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r;
    if (res_push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !res_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[tail_r] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cut_truth_table_simulator.sv =====
// Path: an emitting item goes from the command queue through the issue and combine stages
//   into the result queue, then shows one word per cycle while the result queue is popped.
// Throughput: a kept item takes one issue slot per table word, set by the store's single
//   write port; dropped leaves take no back-end time.
// Reset: rst_n (synchronous, active low) clears the queues and the sequencer. The table
//   store is not cleared; the user must write slots before they are read (not enforced).
`default_nettype none
// ----------------------------------------------------------------------------
// cut_truth_table_simulator: truth tables of a cut, node by node
// Front classifies items into a command queue; back streams table words
// through the store; results leave through a result queue.
// ----------------------------------------------------------------------------
module cut_truth_table_simulator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // item intake
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic                           in_req_type,
  input  wire logic [cts_pkg::SLOT_W-1:0]     in_dest_slot,
  input  wire logic [cts_pkg::SLOT_W-1:0]     in_fanin0_slot,
  input  wire logic [cts_pkg::SLOT_W-1:0]     in_fanin1_slot,
  input  wire logic                           in_fanin0_compl,
  input  wire logic                           in_fanin1_compl,
  input  wire logic                           in_is_xor,
  input  wire logic                           in_emit,
  // result words
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [cts_pkg::WORD_W-1:0]          out_truth_word,
  output logic [cts_pkg::WIDX_OUT_W-1:0]      out_word_index,
  output logic                                out_last
);

  // front -> back command queue
  logic                         cmd_valid;
  cts_pkg::cmd_t                cmd;
  logic                         cmd_pop;
  // back -> result queue
  logic                         res_push;
  cts_pkg::res_t                res;
  logic [cts_pkg::OQ_CNT_W-1:0] oq_count;
  cts_pkg::res_t                out_res;

  // Front: takes an item whenever its two-entry command queue has room.
  // A leaf for a variable beyond the cut is accepted and dropped here.
  cts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_dest_slot    (in_dest_slot),
    .in_fanin0_slot  (in_fanin0_slot),
    .in_fanin1_slot  (in_fanin1_slot),
    .in_fanin0_compl (in_fanin0_compl),
    .in_fanin1_compl (in_fanin1_compl),
    .in_is_xor       (in_is_xor),
    .in_emit         (in_emit),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  // Back: word w of an item is read from the store, then combined and written in the next cycle.
  // Items follow each other with no gap; an emitting item waits until the result
  // queue can hold all of its words, so the back end never drops a word.
  cts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .oq_count  (oq_count),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue: decouples the consumer from the back end.
  cts_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .oq_count  (oq_count),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  assign out_truth_word = out_res.truth_word;
  assign out_word_index = out_res.word_index;
  assign out_last       = out_res.last;

  // result queue never overfills: the back end reserves room first
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
      (oq_count <= cts_pkg::OQ_CNT_W'(cts_pkg::OQ_DEPTH)) &&
      !(res_push && (oq_count == cts_pkg::OQ_CNT_W'(cts_pkg::OQ_DEPTH)) &&
        !(out_pop && !out_empty)))
    else $error("result queue overflow");

  // the back end only takes a command that the front holds
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
      cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // words of an emitted table leave the back end in order, one per cycle
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
      (res_push && !res.last) |=> (res_push && (res.word_index == $past(res.word_index) + 1'b1)))
    else $error("table words out of order");

endmodule
`default_nettype wire
